// ===== rtl/mru_pkg.sv =====
// ----------------------------------------------------------------------------
// mru_pkg
// Shared constants for the mixed-radix index unravel block: configuration
// register indexes and the number of coordinate fields in a result.
// ----------------------------------------------------------------------------
package mru_pkg;

    localparam int NUM_COORDS = 6;
    localparam int CFG_ADDR_BITS = 3;

    typedef logic [CFG_ADDR_BITS-1:0] cfg_addr_t;

    localparam cfg_addr_t REG_RANK = 3'd0;
    localparam cfg_addr_t REG_DIM_SIZE_0 = 3'd1;
    localparam int NUM_DIM_REGS = 6;

endpackage

// ===== rtl/mixed_radix_index_unravel.sv =====
// ----------------------------------------------------------------------------
// mixed_radix_index_unravel
// Splits a flat row-major element index into per-dimension coordinates.
// ----------------------------------------------------------------------------
// The block accepts one index per cycle unless a result held at the output is
// not taken (m_tready low), which stalls the whole pipeline and s_tready. Each
// dimension is handled by a chain of INDEX_BITS restoring-division stages that
// each settle one quotient bit, from the last dimension down to dimension zero,
// and that chain sets the latency. A zero-sized dimension and any dimension at
// or beyond the configured rank pass the running index through unchanged and
// give a zero coordinate; a quotient left after dimension zero is dropped, so
// large indices wrap.
// Configuration must only be written while no transfer is in flight.
module mixed_radix_index_unravel #(
    parameter int MAX_RANK = 6,
    parameter int DIM_BITS = 16,
    parameter int INDEX_BITS = 32
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_we,
    input  mru_pkg::cfg_addr_t                     cfg_addr,
    input  logic [DIM_BITS-1:0]                    cfg_wdata,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // element index
    input  logic [((INDEX_BITS+7)/8)*8-1:0]        s_tdata,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // coord_0, coord_1, coord_2, coord_3, coord_4, coord_5
    output logic [((mru_pkg::NUM_COORDS*DIM_BITS+7)/8)*8-1:0] m_tdata
);

    localparam int NSTG = MAX_RANK * INDEX_BITS;
    localparam int OUT_BITS = mru_pkg::NUM_COORDS * DIM_BITS;
    localparam int OUT_W = ((OUT_BITS + 7) / 8) * 8;
    localparam int RANK_RST = (MAX_RANK < 6) ? MAX_RANK : 6;

    logic [2:0]                              rank_reg;
    logic [MAX_RANK-1:0][DIM_BITS-1:0]       dim_size_reg;

    logic [NSTG-1:0]                         v_reg;
    logic [INDEX_BITS-1:0]                   acc_reg [NSTG];
    logic [DIM_BITS-1:0]                     rem_reg [NSTG];
    logic [MAX_RANK-1:0][DIM_BITS-1:0]       crd_reg [NSTG];

    logic                                    adv;

    assign adv = !v_reg[NSTG-1] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = v_reg[NSTG-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rank_reg <= 3'(RANK_RST);
            for (int i = 0; i < MAX_RANK; i++) begin
                dim_size_reg[i] <= DIM_BITS'(1);
            end
        end else if (cfg_we) begin
            if (cfg_addr == mru_pkg::REG_RANK) begin
                rank_reg <= cfg_wdata[2:0];
            end
            for (int i = 0; i < MAX_RANK; i++) begin
                if (i < mru_pkg::NUM_DIM_REGS &&
                    cfg_addr == mru_pkg::cfg_addr_t'(i + 1)) begin
                    dim_size_reg[i] <= cfg_wdata;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (adv) begin
            v_reg <= {v_reg[NSTG-2:0], s_tvalid};
        end
    end

    genvar s;
    generate
        for (s = 0; s < NSTG; s++) begin : g_stg
            localparam int DIM = MAX_RANK - 1 - s / INDEX_BITS;
            localparam int STEP = s % INDEX_BITS;

            logic [INDEX_BITS-1:0]             acc_in;
            logic [DIM_BITS-1:0]               rem_in;
            logic [MAX_RANK-1:0][DIM_BITS-1:0] crd_in;
            logic [INDEX_BITS-1:0]             acc_next;
            logic [DIM_BITS-1:0]               rem_next;
            logic [MAX_RANK-1:0][DIM_BITS-1:0] crd_next;
            logic                              active;
            logic [DIM_BITS:0]                 trial;
            logic [DIM_BITS:0]                 dvs;
            logic [DIM_BITS:0]                 diff;
            logic                              ge;

            if (s == 0) begin : g_first
                assign acc_in = s_tdata[INDEX_BITS-1:0];
                assign rem_in = '0;
                assign crd_in = '0;
            end else begin : g_next
                assign acc_in = acc_reg[s-1];
                assign rem_in = rem_reg[s-1];
                assign crd_in = crd_reg[s-1];
            end

            always_comb begin
                active = (rank_reg > 3'(DIM)) && (dim_size_reg[DIM] != '0);
                dvs = {1'b0, dim_size_reg[DIM]};
                trial = {rem_in, acc_in[INDEX_BITS-1]};
                ge = trial >= dvs;
                diff = trial - dvs;
                acc_next = acc_in;
                rem_next = rem_in;
                crd_next = crd_in;
                if (active) begin
                    acc_next = {acc_in[INDEX_BITS-2:0], ge};
                    rem_next = ge ? diff[DIM_BITS-1:0] : trial[DIM_BITS-1:0];
                end
                if (STEP == INDEX_BITS - 1) begin
                    if (active) begin
                        crd_next[DIM] = rem_next;
                    end
                    rem_next = '0;
                end
            end

            always_ff @(posedge aclk) begin
                if (adv) begin
                    acc_reg[s] <= acc_next;
                    rem_reg[s] <= rem_next;
                    crd_reg[s] <= crd_next;
                end
            end
        end
    endgenerate

    genvar j;
    generate
        for (j = 0; j < mru_pkg::NUM_COORDS; j++) begin : g_out
            if (j < MAX_RANK) begin : g_used
                assign m_tdata[j*DIM_BITS +: DIM_BITS] = crd_reg[NSTG-1][j];
            end else begin : g_zero
                assign m_tdata[j*DIM_BITS +: DIM_BITS] = '0;
            end
        end
        if (OUT_W > OUT_BITS) begin : g_pad
            assign m_tdata[OUT_W-1:OUT_BITS] = '0;
        end
    endgenerate

`ifndef SYNTHESIS
    genvar k;
    generate
        for (k = 0; k < MAX_RANK && k < mru_pkg::NUM_COORDS; k++) begin : g_chk
            a_unused_zero : assert property (@(posedge aclk) disable iff (!aresetn)
                m_tvalid && (rank_reg <= 3'(k) || dim_size_reg[k] == '0)
                |-> m_tdata[k*DIM_BITS +: DIM_BITS] == '0)
                else $error("coordinate of an unused dimension is not zero");
            a_coord_range : assert property (@(posedge aclk) disable iff (!aresetn)
                m_tvalid && rank_reg > 3'(k) && dim_size_reg[k] != '0
                |-> m_tdata[k*DIM_BITS +: DIM_BITS] < dim_size_reg[k])
                else $error("coordinate not below its dimension size");
        end
    endgenerate
`endif

endmodule

// ===== tb/tb_mixed_radix_index_unravel.sv =====
// ----------------------------------------------------------------------------
// tb_mixed_radix_index_unravel
// Self-checking testbench for the mixed-radix index unravel block. A table of
// directed indices is followed by random indices under several tensor shapes,
// with random gaps on both streams, and every result transfer is compared
// with coordinates computed by a local model of the row-major split.
// ----------------------------------------------------------------------------
module tb_mixed_radix_index_unravel;

    localparam int LATENCY = 192;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct {
        logic [31:0] index;
        logic        has_fixed;
        logic [95:0] fixed;
    } dir_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_we = 1'b0;
    mru_pkg::cfg_addr_t   cfg_addr = '0;
    logic [15:0]          cfg_wdata = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [31:0]          s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [95:0]          m_tdata;

    logic [2:0]  shape_rank;
    logic [15:0] shape_size [mru_pkg::NUM_COORDS];
    logic [95:0] coord_queue [$];
    int          error_count = 0;
    int          result_count = 0;
    int          idle_cycles = 0;
    int          shape_count = 0;
    int          rx_hold = 0;
    logic        rx_stall_en = 1'b1;

    mixed_radix_index_unravel u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic logic [95:0] unravel_coords(logic [31:0] idx);
        logic [31:0] rest;
        logic [95:0] packed_coords;
        int          r;
        rest = idx;
        packed_coords = '0;
        r = (shape_rank > 3'd6) ? 6 : int'(shape_rank);
        while (r > 0) begin
            r--;
            if (shape_size[r] != 16'd0) begin
                packed_coords[r*16 +: 16] = 16'(rest % shape_size[r]);
                rest = rest / shape_size[r];
            end
        end
        return packed_coords;
    endfunction

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
        return 0;
    endfunction

    task automatic report_mismatch(string what, logic [95:0] got, logic [95:0] want);
        error_count++;
        $display("mismatch %0s: got %h expected %h at %0t", what, got, want, $time);
    endtask

    task automatic write_reg(mru_pkg::cfg_addr_t addr, logic [15:0] value);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= value;
        @(posedge aclk);
        if (addr == mru_pkg::REG_RANK) shape_rank = value[2:0];
        else if (addr <= mru_pkg::cfg_addr_t'(mru_pkg::NUM_DIM_REGS))
            shape_size[addr - mru_pkg::REG_DIM_SIZE_0] = value;
    endtask

    task automatic set_shape(logic [2:0] rnk, logic [15:0] s0, logic [15:0] s1,
                             logic [15:0] s2, logic [15:0] s3, logic [15:0] s4,
                             logic [15:0] s5);
        wait (coord_queue.size() == 0);
        repeat (LATENCY + 4) @(posedge aclk);
        write_reg(mru_pkg::REG_RANK, 16'(rnk));
        write_reg(mru_pkg::REG_DIM_SIZE_0, s0);
        write_reg(mru_pkg::REG_DIM_SIZE_0 + 3'd1, s1);
        write_reg(mru_pkg::REG_DIM_SIZE_0 + 3'd2, s2);
        write_reg(mru_pkg::REG_DIM_SIZE_0 + 3'd3, s3);
        write_reg(mru_pkg::REG_DIM_SIZE_0 + 3'd4, s4);
        write_reg(mru_pkg::REG_DIM_SIZE_0 + 3'd5, s5);
        cfg_we <= 1'b0;
        shape_count++;
    endtask

    task automatic send_index(logic [31:0] idx, logic has_fixed, logic [95:0] fixed);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= idx;
        do @(posedge aclk); while (!s_tready);
        if (has_fixed && fixed !== unravel_coords(idx))
            report_mismatch("model vs table", unravel_coords(idx), fixed);
        coord_queue.insert(coord_queue.size(), has_fixed ? fixed : unravel_coords(idx));
    endtask

    task automatic random_burst(int n);
        logic [31:0] idx;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 3))
                0: idx = $urandom_range(0, 255);
                1: idx = 32'({$urandom, $urandom} >> $urandom_range(0, 31));
                default: idx = $urandom;
            endcase
            send_index(idx, 1'b0, '0);
        end
        s_tvalid <= 1'b0;
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            result_count++;
            if (coord_queue.size() == 0) begin
                report_mismatch("unexpected result", m_tdata, '0);
            end else begin
                logic [95:0] want;
                want = coord_queue.pop_front();
                for (int k = 0; k < mru_pkg::NUM_COORDS; k++) begin
                    if (m_tdata[k*16 +: 16] !== want[k*16 +: 16])
                        report_mismatch($sformatf("coord_%0d", k), m_tdata, want);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            m_tready <= 1'b0;
        end else if (rx_stall_en && $urandom_range(0, 9) < 3) begin
            m_tready <= 1'b0;
            rx_hold <= gap_len();
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d results pending", coord_queue.size());
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        dir_row_t rows [$];
        shape_rank = 3'd6;
        for (int k = 0; k < mru_pkg::NUM_COORDS; k++) shape_size[k] = 16'd1;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // After reset every size is one, so every coordinate is zero.
        rows.insert(rows.size(), '{32'h0000_0000, 1'b1, 96'h0});
        rows.insert(rows.size(), '{32'hFFFF_FFFF, 1'b1, 96'h0});
        rows.insert(rows.size(), '{32'h1234_5678, 1'b1, 96'h0});
        foreach (rows[i]) send_index(rows[i].index, rows[i].has_fixed, rows[i].fixed);
        s_tvalid <= 1'b0;

        set_shape(3'd6, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        rows = {};
        rows.insert(rows.size(), '{32'hFFFF_FFFF, 1'b0, 96'h0});
        rows.insert(rows.size(), '{32'h0000_FFFF, 1'b0, 96'h0});
        rows.insert(rows.size(), '{32'h0000_FFFE, 1'b0, 96'h0});
        foreach (rows[i]) send_index(rows[i].index, rows[i].has_fixed, rows[i].fixed);
        s_tvalid <= 1'b0;

        set_shape(3'd3, 16'd4, 16'd0, 16'd10, 16'd7, 16'd7, 16'd7);
        for (int v = 0; v < 8; v++) send_index(32'(v * 7 + 3), 1'b0, '0);
        send_index(32'hFFFF_FFFF, 1'b0, '0);
        s_tvalid <= 1'b0;

        set_shape(3'd0, 16'd3, 16'd3, 16'd3, 16'd3, 16'd3, 16'd3);
        send_index(32'hDEAD_BEEF, 1'b1, 96'h0);
        s_tvalid <= 1'b0;
        set_shape(3'd7, 16'd2, 16'd3, 16'd5, 16'd7, 16'd11, 16'd13);
        send_index(32'd29, 1'b0, '0);
        send_index(32'd30029, 1'b0, '0);
        s_tvalid <= 1'b0;
        set_shape(3'd1, 16'd0, 16'd5, 16'd5, 16'd5, 16'd5, 16'd5);
        send_index(32'h8000_0001, 1'b1, 96'h0);
        s_tvalid <= 1'b0;

        for (int p = 0; p < 7; p++) begin
            logic [15:0] sz [mru_pkg::NUM_COORDS];
            for (int k = 0; k < mru_pkg::NUM_COORDS; k++) begin
                case ($urandom_range(0, 5))
                    0: sz[k] = 16'd0;
                    1: sz[k] = 16'hFFFF;
                    2: sz[k] = 16'($urandom);
                    default: sz[k] = 16'($urandom_range(1, 16));
                endcase
            end
            set_shape(3'($urandom_range(0, 7)), sz[0], sz[1], sz[2], sz[3], sz[4], sz[5]);
            rx_stall_en = (p != 3);
            random_burst(150);
        end
        rx_stall_en = 1'b1;

        wait (coord_queue.size() == 0);
        repeat (LATENCY + 20) @(posedge aclk);
        $display("covered %0d tensor shapes and %0d result transfers", shape_count,
                 result_count);
        if (error_count == 0 && coord_queue.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

// ===== files.f =====
rtl/mru_pkg.sv
rtl/mixed_radix_index_unravel.sv
tb/tb_mixed_radix_index_unravel.sv
